@@ sv/sparse_triplet_matrix_multiply_unit_macros.svh @@
// assertion macros shared by the checker of the sparse triplet matrix multiply unit
`ifndef SPARSE_TRIPLET_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define SPARSE_TRIPLET_MATRIX_MULTIPLY_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define STMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stmm check failed");

// consequent must hold in the cycle after the antecedent
`define STMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stmm check failed");

`endif

@@ sv/stmm_pkg.sv @@
// shared constants, types and helper functions of the sparse triplet matrix multiply unit
`default_nettype none

package stmm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int STORE_DEPTH = 256;

  localparam int CFG_W     = 5;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int POS_W     = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PROD_W    = 2 * DIM_W;
  localparam int VAL_W     = 32;
  localparam int OUT_IDX_W = 4;

  localparam int REG_IDX_W = 2;
  localparam int APB_AW    = REG_IDX_W + 2;
  localparam int APB_DW    = 32;

  // register indexes on the config port
  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_FETCH   = 2'd2,
    OP_NEW_JOB = 2'd3
  } op_e;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } trip_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (32'(d) > MAX_DIM) return DIM_W'(MAX_DIM);
    return DIM_W'(d);
  endfunction

  // element count of an r by c matrix, limited to the store depth
  function automatic logic [POS_W-1:0] capped_total(input logic [DIM_W-1:0] r,
                                                    input logic [DIM_W-1:0] c);
    logic [PROD_W-1:0] t;
    t = PROD_W'(r) * PROD_W'(c);
    return (32'(t) > STORE_DEPTH) ? POS_W'(STORE_DEPTH) : POS_W'(t);
  endfunction

endpackage

`default_nettype wire

@@ sv/stmm_ram.sv @@
// generic single write port, single read port ram with registered read data
`default_nettype none

module stmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/stmm_div.sv @@
// iterative restoring divider, one quotient bit per cycle, for position to row and column
`default_nettype none

module stmm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stmm_pkg::div_req_t req_i,
  output stmm_pkg::div_rsp_t rsp_o
);

  import stmm_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIM_W-1:0] dsr_q, dsr_d;
  logic [DIM_W:0]   trial;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[POS_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(POS_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[POS_W-2:0], ge};
      rem_d = ge ? DIM_W'(trial - {1'b0, dsr_q}) : trial[DIM_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/sparse_triplet_matrix_multiply_unit.sv @@
// sparse triplet matrix multiply unit: request decode, product pass sequencer, apb registers
// one request at a time: a load that is ignored or zero skips the divider, a stored triplet goes through it
// fetch: product entry read while the 9-step divider gives row and column; early skips both
// last b load runs the pass: each a triplet is read (S_AREQ, S_ADAT), a kept one walks
// all b triplets (S_BREQ, S_BDAT), a match adds S_PWR; output stalls hold a fetch
// reset: async active low, dims to 1, job state cleared, product store zero via valid bits
`default_nettype none

module sparse_triplet_matrix_multiply_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic signed [stmm_pkg::VAL_W-1:0]    value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [stmm_pkg::VAL_W-1:0]    product_value_o,
  output logic [stmm_pkg::OUT_IDX_W-1:0]       product_row_o,
  output logic [stmm_pkg::OUT_IDX_W-1:0]       product_col_o,
  output logic                                 last_o,
  output logic                                 ready_res_o,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stmm_pkg::APB_AW-1:0]          paddr,
  input  logic [stmm_pkg::APB_DW-1:0]          pwdata,
  output logic [stmm_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  import stmm_pkg::*;

  localparam int IW         = IDX_W + DIM_W + 1;
  localparam int TRIP_DEPTH = 2 ** (ADDR_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a request
    S_LDIV,   // load: divider turns position into row and column
    S_AREQ,   // pass: read next a triplet
    S_ADAT,   // pass: a triplet on the read port
    S_BREQ,   // pass: read next b triplet
    S_BDAT,   // pass: b triplet on the read port, read product entry
    S_PWR,    // pass: accumulate into product entry
    S_FLAT,   // fetch: product entry on the read port
    S_FWAIT   // fetch: wait for divider and a free output register
  } state_e;

  state_e state_q, state_d;

  // dimension registers, raw as written
  logic [CFG_W-1:0] rows_q, rows_d, inner_q, inner_d, cols_q, cols_d;

  // job state
  logic [POS_W-1:0]       cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [POS_W-1:0]       pos_a_q, pos_a_d, pos_b_q, pos_b_d;
  logic [ADDR_W-1:0]      fptr_q, fptr_d;
  logic                   done_q, done_d;
  logic [STORE_DEPTH-1:0] pv_q, pv_d;

  // per-request working registers
  logic              is_b_q, is_b_d;
  logic              trig_q, trig_d;
  logic [VAL_W-1:0]  lval_q, lval_d;
  logic [POS_W-1:0]  i_q, i_d, j_q, j_d;
  trip_t             a_q, a_d;
  logic [VAL_W-1:0]  mult_q, mult_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic [POS_W-1:0]  fp_q, fp_d;
  logic              flast_q, flast_d;
  logic              frdy_q, frdy_d;
  logic [VAL_W-1:0]  fval_q, fval_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [VAL_W-1:0]     out_val_q, out_val_d;
  logic [OUT_IDX_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic                 out_last_q, out_last_d;
  logic                 out_rdy_q, out_rdy_d;

  // live dimensions and element counts
  logic [DIM_W-1:0] r, k, c;
  logic [POS_W-1:0] tot_a, tot_b, tot_p;

  op_e              op;
  logic             accept, out_free, cfg_we;
  logic [POS_W-1:0] lpos, ltot, lcnt;
  logic             in_rng, store_it, trig;
  logic [POS_W-1:0] fp, fp_inc;

  // memories
  logic                     trip_we;
  logic [ADDR_W:0]          trip_waddr, trip_raddr;
  trip_t                    trip_wdata, trip_rd;
  logic [$bits(trip_t)-1:0] trip_rdata;
  logic                     prod_we;
  logic [ADDR_W-1:0]        prod_raddr;
  logic [VAL_W-1:0]         prod_wdata, prod_rdata, prod_old;

  logic [IW-1:0]    idx;
  logic             b_ok;
  logic [VAL_W-1:0] mult;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign r     = eff_dim(rows_q);
  assign k     = eff_dim(inner_q);
  assign c     = eff_dim(cols_q);
  assign tot_a = capped_total(r, k);
  assign tot_b = capped_total(k, c);
  assign tot_p = capped_total(r, c);

  assign op         = op_e'(op_i);
  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // load request view: a loads use r by k, b loads use k by c
  assign lpos     = (op == OP_LOAD_A) ? pos_a_q : pos_b_q;
  assign ltot     = (op == OP_LOAD_A) ? tot_a : tot_b;
  assign lcnt     = (op == OP_LOAD_A) ? cnt_a_q : cnt_b_q;
  assign in_rng   = lpos < ltot;
  assign store_it = in_rng && (value_i != '0) && (lcnt < POS_W'(STORE_DEPTH));
  assign trig     = (op == OP_LOAD_B) && in_rng && ((pos_b_q + 1'b1) == tot_b);

  // fetch pointer restarts at the first element when at or beyond the current count
  assign fp     = (POS_W'(fptr_q) >= tot_p) ? '0 : POS_W'(fptr_q);
  assign fp_inc = fp + 1'b1;

  // one position divider shared by loads and fetches
  assign div_req.start    = accept && (((op == OP_LOAD_A || op == OP_LOAD_B) && store_it) ||
                                       (op == OP_FETCH && done_q));
  assign div_req.dividend = (op == OP_FETCH) ? fp : lpos;
  assign div_req.divisor  = (op == OP_LOAD_A) ? k : c;

  stmm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // triplet store: a triplets in the lower half, b triplets in the upper half
  assign trip_we          = (state_q == S_LDIV) && div_rsp.done;
  assign trip_waddr       = {is_b_q, (is_b_q ? cnt_b_q[ADDR_W-1:0] : cnt_a_q[ADDR_W-1:0])};
  assign trip_wdata.row   = IDX_W'(div_rsp.quot);
  assign trip_wdata.col   = IDX_W'(div_rsp.rem);
  assign trip_wdata.val   = lval_q;
  assign trip_raddr       = (state_q == S_BREQ) ? {1'b1, j_q[ADDR_W-1:0]} :
                                                  {1'b0, i_q[ADDR_W-1:0]};
  assign trip_rd          = trip_t'(trip_rdata);

  stmm_ram #(
    .WIDTH ($bits(trip_t)),
    .DEPTH (TRIP_DEPTH)
  ) u_trip_ram (
    .clk_i   (clk_i),
    .we_i    (trip_we),
    .waddr_i (trip_waddr),
    .wdata_i (trip_wdata),
    .raddr_i (trip_raddr),
    .rdata_o (trip_rdata)
  );

  // pair check on the b triplet just read against the held a triplet
  assign idx  = IW'(a_q.row) * IW'(c) + IW'(trip_rd.col);
  assign b_ok = (DIM_W'(trip_rd.row) < k) && (DIM_W'(trip_rd.col) < c) &&
                (a_q.col == trip_rd.row) && (32'(idx) < STORE_DEPTH);
  assign mult = a_q.val * trip_rd.val;

  // product store: entries without a valid bit read as zero
  assign prod_we    = state_q == S_PWR;
  assign prod_old   = pv_q[pidx_q] ? prod_rdata : '0;
  assign prod_wdata = prod_old + mult_q;
  assign prod_raddr = (state_q == S_BDAT) ? idx[ADDR_W-1:0] : fp[ADDR_W-1:0];

  stmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_prod_ram (
    .clk_i   (clk_i),
    .we_i    (prod_we),
    .waddr_i (pidx_q),
    .wdata_i (prod_wdata),
    .raddr_i (prod_raddr),
    .rdata_o (prod_rdata)
  );

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_ROWS_A:    prdata = APB_DW'(rows_q);
      REG_INNER_DIM: prdata = APB_DW'(inner_q);
      REG_COLS_B:    prdata = APB_DW'(cols_q);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    inner_d     = inner_q;
    cols_d      = cols_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    pos_a_d     = pos_a_q;
    pos_b_d     = pos_b_q;
    fptr_d      = fptr_q;
    done_d      = done_q;
    pv_d        = pv_q;
    is_b_d      = is_b_q;
    trig_d      = trig_q;
    lval_d      = lval_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    mult_d      = mult_q;
    pidx_d      = pidx_q;
    fp_d        = fp_q;
    flast_d     = flast_q;
    frdy_d      = frdy_q;
    fval_d      = fval_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    out_rdy_d   = out_rdy_q;

    if (cfg_we) begin
      unique case (paddr[APB_AW-1:2])
        REG_ROWS_A:    rows_d  = pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_d = pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_d  = pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end

    // result taken by the consumer
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_LOAD_A, OP_LOAD_B: begin
              if (in_rng) begin
                if (op == OP_LOAD_A) begin
                  pos_a_d = pos_a_q + 1'b1;
                end else begin
                  pos_b_d = pos_b_q + 1'b1;
                end
                is_b_d = op == OP_LOAD_B;
                lval_d = value_i;
                trig_d = trig;
                if (store_it) begin
                  state_d = S_LDIV;
                end else if (trig) begin
                  // last b element is zero or the store is full: start the pass right away
                  pv_d    = '0;
                  i_d     = '0;
                  state_d = S_AREQ;
                end
              end
            end
            OP_FETCH: begin
              frdy_d = done_q;
              if (done_q) begin
                fp_d    = fp;
                flast_d = fp_inc == tot_p;
                fptr_d  = (fp_inc >= tot_p) ? '0 : ADDR_W'(fp_inc);
                state_d = S_FLAT;
              end else begin
                state_d = S_FWAIT;
              end
            end
            OP_NEW_JOB: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
              pos_a_d = '0;
              pos_b_d = '0;
              fptr_d  = '0;
              done_d  = 1'b0;
              pv_d    = '0;
            end
            default: ;
          endcase
        end
      end

      S_LDIV: begin
        if (div_rsp.done) begin
          if (is_b_q) begin
            cnt_b_d = cnt_b_q + 1'b1;
          end else begin
            cnt_a_d = cnt_a_q + 1'b1;
          end
          if (trig_q) begin
            pv_d    = '0;
            i_d     = '0;
            state_d = S_AREQ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_AREQ: begin
        if (i_q >= cnt_a_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ADAT;
        end
      end

      S_ADAT: begin
        // a triplets outside the current dimensions take no part
        if ((DIM_W'(trip_rd.row) < r) && (DIM_W'(trip_rd.col) < k)) begin
          a_d     = trip_rd;
          j_d     = '0;
          state_d = S_BREQ;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_AREQ;
        end
      end

      S_BREQ: begin
        if (j_q >= cnt_b_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_AREQ;
        end else begin
          state_d = S_BDAT;
        end
      end

      S_BDAT: begin
        if (b_ok) begin
          pidx_d  = idx[ADDR_W-1:0];
          mult_d  = mult;
          state_d = S_PWR;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_BREQ;
        end
      end

      S_PWR: begin
        pv_d[pidx_q] = 1'b1;
        j_d          = j_q + 1'b1;
        state_d      = S_BREQ;
      end

      S_FLAT: begin
        fval_d  = pv_q[fp_q[ADDR_W-1:0]] ? prod_rdata : '0;
        state_d = S_FWAIT;
      end

      S_FWAIT: begin
        if ((!frdy_q || div_rsp.done) && out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = frdy_q ? fval_q : '0;
          out_row_d   = frdy_q ? div_rsp.quot[OUT_IDX_W-1:0] : '0;
          out_col_d   = frdy_q ? OUT_IDX_W'(div_rsp.rem) : '0;
          out_last_d  = frdy_q && flast_q;
          out_rdy_d   = frdy_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= CFG_W'(1);
      inner_q     <= CFG_W'(1);
      cols_q      <= CFG_W'(1);
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      pos_a_q     <= '0;
      pos_b_q     <= '0;
      fptr_q      <= '0;
      done_q      <= 1'b0;
      pv_q        <= '0;
      is_b_q      <= 1'b0;
      trig_q      <= 1'b0;
      lval_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      a_q         <= '0;
      mult_q      <= '0;
      pidx_q      <= '0;
      fp_q        <= '0;
      flast_q     <= 1'b0;
      frdy_q      <= 1'b0;
      fval_q      <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
      out_rdy_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      inner_q     <= inner_d;
      cols_q      <= cols_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      pos_a_q     <= pos_a_d;
      pos_b_q     <= pos_b_d;
      fptr_q      <= fptr_d;
      done_q      <= done_d;
      pv_q        <= pv_d;
      is_b_q      <= is_b_d;
      trig_q      <= trig_d;
      lval_q      <= lval_d;
      i_q         <= i_d;
      j_q         <= j_d;
      a_q         <= a_d;
      mult_q      <= mult_d;
      pidx_q      <= pidx_d;
      fp_q        <= fp_d;
      flast_q     <= flast_d;
      frdy_q      <= frdy_d;
      fval_q      <= fval_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_last_q  <= out_last_d;
      out_rdy_q   <= out_rdy_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_val_q;
  assign product_row_o   = out_row_q;
  assign product_col_o   = out_col_q;
  assign last_o          = out_last_q;
  assign ready_res_o     = out_rdy_q;

endmodule

`default_nettype wire

@@ sv/stmm_checker.sv @@
// port-level checker of the sparse triplet matrix multiply unit and its bind
`default_nettype none
`include "sparse_triplet_matrix_multiply_unit_macros.svh"

module stmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  op_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] product_value_o,
  input logic [3:0]  product_row_o,
  input logic [3:0]  product_col_o,
  input logic        last_o,
  input logic        ready_res_o
);

  import stmm_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  `STMM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(product_value_o))

  // an early fetch returns a zero value and no last flag
  `STMM_ASSERT_NOW(a_early_zero, out_valid_o && !ready_res_o, !last_o && product_value_o == '0)

  // an early fetch carries no coordinates
  `STMM_ASSERT_NOW(a_early_idx, out_valid_o && !ready_res_o, product_row_o == '0 && product_col_o == '0)

  // an accepted fetch request always leaves the unit busy, stalling new requests
  `STMM_ASSERT_NEXT(a_fetch_busy, in_acc && op_i == OP_FETCH, in_stall_o)

  // a new job request completes in its own cycle
  `STMM_ASSERT_NEXT(a_new_job_quick, in_acc && op_i == OP_NEW_JOB, !in_stall_o)

endmodule

bind sparse_triplet_matrix_multiply_unit stmm_checker u_stmm_checker (.*);

`default_nettype wire
